// ===== rtl/color_sensor_pulse_to_rgb_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the color sensor pulse to RGB unit
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef COLOR_SENSOR_PULSE_TO_RGB_UNIT_ASSERT_SVH
`define COLOR_SENSOR_PULSE_TO_RGB_UNIT_ASSERT_SVH

// same-cycle implication
`define CSP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CSP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/csp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csp_pkg
// Shared types and constants of the color sensor pulse to RGB unit.
// ----------------------------------------------------------------------------
package csp_pkg;

  localparam int CFG_W    = 20;
  localparam int LEVEL_W  = 8;
  localparam int IDX_W    = 3;
  localparam int DIV_W    = CFG_W + LEVEL_W;
  localparam int ITER_W   = $clog2(LEVEL_W);

  localparam logic [IDX_W-1:0] REG_RED_LOW    = 3'd0;
  localparam logic [IDX_W-1:0] REG_RED_HIGH   = 3'd1;
  localparam logic [IDX_W-1:0] REG_GREEN_LOW  = 3'd2;
  localparam logic [IDX_W-1:0] REG_GREEN_HIGH = 3'd3;
  localparam logic [IDX_W-1:0] REG_BLUE_LOW   = 3'd4;
  localparam logic [IDX_W-1:0] REG_BLUE_HIGH  = 3'd5;
  localparam logic [IDX_W-1:0] REG_SETTLE     = 3'd6;

  localparam logic [CFG_W-1:0] RST_RED_LOW    = 20'd15000;
  localparam logic [CFG_W-1:0] RST_RED_HIGH   = 20'd43066;
  localparam logic [CFG_W-1:0] RST_GREEN_LOW  = 20'd24000;
  localparam logic [CFG_W-1:0] RST_GREEN_HIGH = 20'd42000;
  localparam logic [CFG_W-1:0] RST_BLUE_LOW   = 20'd15000;
  localparam logic [CFG_W-1:0] RST_BLUE_HIGH  = 20'd42000;
  localparam logic [CFG_W-1:0] RST_SETTLE     = 20'd84000;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef logic [LEVEL_W-1:0] level_t;

  typedef struct packed {
    logic [CFG_W-1:0] red_low;
    logic [CFG_W-1:0] red_high;
    logic [CFG_W-1:0] green_low;
    logic [CFG_W-1:0] green_high;
    logic [CFG_W-1:0] blue_low;
    logic [CFG_W-1:0] blue_high;
  } csp_cal_t;

  typedef struct packed {
    logic       filter_s2;
    logic       filter_s3;
    logic       busy;
    logic       last;
    logic       need_map;
    logic [1:0] ch;
  } csp_ctl_t;

endpackage

// ===== rtl/csp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csp_front
// Per-tick sequencer: filter select, settle wait, edge search and pulse count.
// ----------------------------------------------------------------------------
module csp_front #(
  parameter int COUNT_WIDTH = 20
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept,
  input  logic                     sensor_level,
  input  logic                     start_req,
  input  logic [csp_pkg::CFG_W-1:0] settle,
  output csp_pkg::csp_ctl_t        ctl,
  output logic [COUNT_WIDTH-1:0]   count
);

  localparam int TICK_W = (COUNT_WIDTH > csp_pkg::CFG_W) ? COUNT_WIDTH : csp_pkg::CFG_W;
  localparam logic [TICK_W-1:0] COUNT_MAX = TICK_W'((64'd1 << COUNT_WIDTH) - 64'd1);

  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_SETTLE    = 3'd1;
  localparam logic [2:0] PH_WAIT_LOW  = 3'd2;
  localparam logic [2:0] PH_WAIT_HIGH = 3'd3;
  localparam logic [2:0] PH_COUNT     = 3'd4;

  logic [2:0]        phase_r, phase_nxt;
  logic [1:0]        channel_r, channel_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [1:0]        ch_sel;
  logic              need_map;
  logic              last;

  always_comb begin
    phase_nxt   = phase_r;
    channel_nxt = channel_r;
    tick_nxt    = tick_r;
    need_map    = 1'b0;
    last        = 1'b0;
    ch_sel      = (channel_r > csp_pkg::CH_BLUE) ? csp_pkg::CH_BLUE : channel_r;
    case (phase_r)
      PH_IDLE: begin
        if (start_req) begin
          channel_nxt = csp_pkg::CH_RED;
          tick_nxt    = '0;
          phase_nxt   = PH_SETTLE;
        end
      end
      PH_SETTLE: begin
        if (tick_r >= TICK_W'(settle)) begin
          tick_nxt  = '0;
          phase_nxt = PH_WAIT_LOW;
        end else begin
          tick_nxt = tick_r + TICK_W'(1);
        end
      end
      PH_WAIT_LOW: begin
        if (!sensor_level) begin
          phase_nxt = PH_WAIT_HIGH;
        end
      end
      PH_WAIT_HIGH: begin
        if (sensor_level) begin
          tick_nxt  = TICK_W'(1);
          phase_nxt = PH_COUNT;
        end
      end
      PH_COUNT: begin
        if (sensor_level) begin
          if (tick_r < COUNT_MAX) begin
            tick_nxt = tick_r + TICK_W'(1);
          end
        end else begin
          need_map = 1'b1;
          tick_nxt = '0;
          if (ch_sel != csp_pkg::CH_BLUE) begin
            channel_nxt = ch_sel + 2'd1;
            phase_nxt   = PH_SETTLE;
          end else begin
            channel_nxt = csp_pkg::CH_RED;
            phase_nxt   = PH_IDLE;
            last        = 1'b1;
          end
        end
      end
      default: begin
        phase_nxt   = PH_IDLE;
        channel_nxt = csp_pkg::CH_RED;
        tick_nxt    = '0;
      end
    endcase
  end

  always_comb begin
    ctl.filter_s2 = (channel_nxt == csp_pkg::CH_GREEN);
    ctl.filter_s3 = (channel_nxt != csp_pkg::CH_RED);
    ctl.busy      = (phase_nxt != PH_IDLE);
    ctl.last      = last;
    ctl.need_map  = need_map;
    ctl.ch        = ch_sel;
    count         = tick_r[COUNT_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      channel_r <= csp_pkg::CH_RED;
      tick_r    <= '0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      channel_r <= channel_nxt;
      tick_r    <= tick_nxt;
    end
  end

endmodule

// ===== rtl/csp_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csp_fifo
// Short word queue between the sequencer and the mapping back end.
// ----------------------------------------------------------------------------
module csp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/csp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csp_back
// Count to brightness mapping with a bit-serial divider, and the result register.
// ----------------------------------------------------------------------------
module csp_back #(
  parameter int COUNT_WIDTH = 20
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_empty,
  input  csp_pkg::csp_ctl_t      q_ctl,
  input  logic [COUNT_WIDTH-1:0] q_count,
  output logic                   q_pop,
  input  csp_pkg::csp_cal_t      cal,
  output logic                   out_valid,
  input  logic                   out_pop,
  output logic                   out_filter_s2,
  output logic                   out_filter_s3,
  output logic                   out_busy_res,
  output logic                   out_color_valid,
  output csp_pkg::level_t        out_red_level,
  output csp_pkg::level_t        out_green_level,
  output csp_pkg::level_t        out_blue_level
);

  localparam int TICK_W = (COUNT_WIDTH > csp_pkg::CFG_W) ? COUNT_WIDTH : csp_pkg::CFG_W;
  localparam int CW     = csp_pkg::CFG_W;
  localparam int DW     = csp_pkg::DIV_W;
  localparam int LW     = csp_pkg::LEVEL_W;
  localparam int IW     = csp_pkg::ITER_W;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_PREP = 3'd1;
  localparam logic [2:0] B_NUM  = 3'd2;
  localparam logic [2:0] B_DIV  = 3'd3;
  localparam logic [2:0] B_DONE = 3'd4;

  logic [2:0]              state_r, state_nxt;
  csp_pkg::csp_ctl_t       ctl_r, ctl_nxt;
  logic [COUNT_WIDTH-1:0]  count_r, count_nxt;
  logic                    le_lo_r, le_lo_nxt;
  logic                    hi_le_lo_r, hi_le_lo_nxt;
  logic [TICK_W-1:0]       d_r, d_nxt;
  logic [CW-1:0]           r_r, r_nxt;
  logic [DW-1:0]           rem_r, rem_nxt;
  logic [DW-1:0]           dv_r, dv_nxt;
  logic [LW-1:0]           q_r, q_nxt;
  logic [IW-1:0]           iter_r, iter_nxt;
  csp_pkg::level_t         res_r, res_nxt;
  csp_pkg::level_t         red_r, red_nxt;
  csp_pkg::level_t         green_r, green_nxt;
  csp_pkg::level_t         blue_r, blue_nxt;
  logic                    out_valid_r, out_valid_nxt;
  csp_pkg::csp_ctl_t       out_ctl_r, out_ctl_nxt;
  csp_pkg::level_t         out_red_r, out_red_nxt;
  csp_pkg::level_t         out_green_r, out_green_nxt;
  csp_pkg::level_t         out_blue_r, out_blue_nxt;
  logic [CW-1:0]           lo, hi;
  logic                    slot_free;
  logic                    ge;
  logic [DW-1:0]           d_ext;
  csp_pkg::level_t         red_sel, green_sel, blue_sel;

  assign slot_free = !out_valid_r || out_pop;
  assign ge        = (rem_r >= dv_r);
  assign d_ext     = DW'(d_r[CW-1:0]);

  always_comb begin
    case (ctl_r.ch)
      csp_pkg::CH_RED: begin
        lo = cal.red_low;
        hi = cal.red_high;
      end
      csp_pkg::CH_GREEN: begin
        lo = cal.green_low;
        hi = cal.green_high;
      end
      default: begin
        lo = cal.blue_low;
        hi = cal.blue_high;
      end
    endcase
  end

  always_comb begin
    red_sel   = (ctl_r.ch == csp_pkg::CH_RED)   ? res_r : red_r;
    green_sel = (ctl_r.ch == csp_pkg::CH_GREEN) ? res_r : green_r;
    blue_sel  = (ctl_r.ch == csp_pkg::CH_BLUE)  ? res_r : blue_r;
  end

  always_comb begin
    state_nxt     = state_r;
    ctl_nxt       = ctl_r;
    count_nxt     = count_r;
    le_lo_nxt     = le_lo_r;
    hi_le_lo_nxt  = hi_le_lo_r;
    d_nxt         = d_r;
    r_nxt         = r_r;
    rem_nxt       = rem_r;
    dv_nxt        = dv_r;
    q_nxt         = q_r;
    iter_nxt      = iter_r;
    res_nxt       = res_r;
    red_nxt       = red_r;
    green_nxt     = green_r;
    blue_nxt      = blue_r;
    out_valid_nxt = out_valid_r && !out_pop;
    out_ctl_nxt   = out_ctl_r;
    out_red_nxt   = out_red_r;
    out_green_nxt = out_green_r;
    out_blue_nxt  = out_blue_r;
    q_pop         = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!q_empty && q_ctl.need_map) begin
          q_pop     = 1'b1;
          ctl_nxt   = q_ctl;
          count_nxt = q_count;
          state_nxt = B_PREP;
        end else if (!q_empty && slot_free) begin
          q_pop         = 1'b1;
          out_valid_nxt = 1'b1;
          out_ctl_nxt   = q_ctl;
          out_red_nxt   = '0;
          out_green_nxt = '0;
          out_blue_nxt  = '0;
        end
      end
      B_PREP: begin
        le_lo_nxt    = (TICK_W'(count_r) <= TICK_W'(lo));
        hi_le_lo_nxt = (hi <= lo);
        d_nxt        = TICK_W'(count_r) - TICK_W'(lo);
        r_nxt        = hi - lo;
        state_nxt    = B_NUM;
      end
      B_NUM: begin
        if (le_lo_r) begin
          res_nxt   = '1;
          state_nxt = B_DONE;
        end else if (hi_le_lo_r || (d_r >= TICK_W'(r_r))) begin
          res_nxt   = '0;
          state_nxt = B_DONE;
        end else begin
          rem_nxt   = (d_ext << LW) - d_ext + DW'(r_r) - DW'(1);
          dv_nxt    = DW'(r_r) << (LW - 1);
          q_nxt     = '0;
          iter_nxt  = IW'(LW - 1);
          state_nxt = B_DIV;
        end
      end
      B_DIV: begin
        rem_nxt  = ge ? (rem_r - dv_r) : rem_r;
        dv_nxt   = dv_r >> 1;
        q_nxt    = {q_r[LW-2:0], ge};
        iter_nxt = iter_r - IW'(1);
        if (iter_r == '0) begin
          res_nxt   = ~{q_r[LW-2:0], ge};
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        if (slot_free) begin
          red_nxt       = red_sel;
          green_nxt     = green_sel;
          blue_nxt      = blue_sel;
          out_valid_nxt = 1'b1;
          out_ctl_nxt   = ctl_r;
          out_red_nxt   = ctl_r.last ? red_sel   : '0;
          out_green_nxt = ctl_r.last ? green_sel : '0;
          out_blue_nxt  = ctl_r.last ? blue_sel  : '0;
          state_nxt     = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ctl_r       <= ctl_nxt;
    count_r     <= count_nxt;
    le_lo_r     <= le_lo_nxt;
    hi_le_lo_r  <= hi_le_lo_nxt;
    d_r         <= d_nxt;
    r_r         <= r_nxt;
    rem_r       <= rem_nxt;
    dv_r        <= dv_nxt;
    q_r         <= q_nxt;
    iter_r      <= iter_nxt;
    res_r       <= res_nxt;
    out_ctl_r   <= out_ctl_nxt;
    out_red_r   <= out_red_nxt;
    out_green_r <= out_green_nxt;
    out_blue_r  <= out_blue_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      red_r       <= '0;
      green_r     <= '0;
      blue_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      red_r       <= red_nxt;
      green_r     <= green_nxt;
      blue_r      <= blue_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_filter_s2   = out_ctl_r.filter_s2;
  assign out_filter_s3   = out_ctl_r.filter_s3;
  assign out_busy_res    = out_ctl_r.busy;
  assign out_color_valid = out_ctl_r.last;
  assign out_red_level   = out_red_r;
  assign out_green_level = out_green_r;
  assign out_blue_level  = out_blue_r;

`include "color_sensor_pulse_to_rgb_unit_assert.svh"

  `CSP_ASSERT_IMP(a_div_rem_bound, state_r == B_DIV, rem_r < (dv_r << 1),
                  "divider remainder out of range")
  `CSP_ASSERT_NXT(a_out_hold, out_valid_r && !out_pop, out_valid_r,
                  "result word dropped before pop")
  `CSP_ASSERT_IMP(a_levels_zero, out_valid_r && !out_ctl_r.last,
                  (out_red_r == '0) && (out_green_r == '0) && (out_blue_r == '0),
                  "levels nonzero without color_valid")

endmodule

// ===== rtl/color_sensor_pulse_to_rgb_unit.sv =====
`timescale 1ns / 1ps
// Path: a plain tick's word goes through the queue and is popped into the result register;
//   a tick that closes a color goes through queue pop, prepare, numerator, 8 divider steps
//   and writeback, and skips the divider when the count lands outside the bounds.
// Throughput: 1 tick per cycle while the back end keeps up; a mapping stops the queue
//   until its writeback, so QUEUE_DEPTH words fill it and full holds the rest.
// Reset: synchronous active-low; sequencer idle on red, queue and result empty,
//   calibration registers back to their defaults. No clearing pass.
// ----------------------------------------------------------------------------
// color_sensor_pulse_to_rgb_unit
// Light-to-frequency color sensor reader producing red, green and blue bytes.
// ----------------------------------------------------------------------------
module color_sensor_pulse_to_rgb_unit #(
  parameter int COUNT_WIDTH = 20,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic                        in_sensor_level,
  input  logic                        in_start_req,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic                        out_filter_s2,
  output logic                        out_filter_s3,
  output logic                        out_busy_res,
  output logic                        out_color_valid,
  output logic [7:0]                  out_red_level,
  output logic [7:0]                  out_green_level,
  output logic [7:0]                  out_blue_level,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [csp_pkg::IDX_W-1:0]   cfg_index,
  input  logic [csp_pkg::CFG_W-1:0]   cfg_data
);

  localparam int QW = $bits(csp_pkg::csp_ctl_t) + COUNT_WIDTH;

  csp_pkg::csp_cal_t            cal_r, cal_nxt;
  logic [csp_pkg::CFG_W-1:0]    settle_r, settle_nxt;
  logic                         accept;
  logic                         q_full, q_empty, q_pop;
  csp_pkg::csp_ctl_t            f_ctl, q_ctl;
  logic [COUNT_WIDTH-1:0]       f_count, q_count;
  logic [QW-1:0]                q_din, q_dout;
  logic                         out_valid;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;
  assign accept    = in_push && !q_full;
  assign out_empty = !out_valid;

  always_comb begin
    cal_nxt    = cal_r;
    settle_nxt = settle_r;
    if (cfg_valid) begin
      case (cfg_index)
        csp_pkg::REG_RED_LOW:    cal_nxt.red_low    = cfg_data;
        csp_pkg::REG_RED_HIGH:   cal_nxt.red_high   = cfg_data;
        csp_pkg::REG_GREEN_LOW:  cal_nxt.green_low  = cfg_data;
        csp_pkg::REG_GREEN_HIGH: cal_nxt.green_high = cfg_data;
        csp_pkg::REG_BLUE_LOW:   cal_nxt.blue_low   = cfg_data;
        csp_pkg::REG_BLUE_HIGH:  cal_nxt.blue_high  = cfg_data;
        csp_pkg::REG_SETTLE:     settle_nxt         = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r.red_low    <= csp_pkg::RST_RED_LOW;
      cal_r.red_high   <= csp_pkg::RST_RED_HIGH;
      cal_r.green_low  <= csp_pkg::RST_GREEN_LOW;
      cal_r.green_high <= csp_pkg::RST_GREEN_HIGH;
      cal_r.blue_low   <= csp_pkg::RST_BLUE_LOW;
      cal_r.blue_high  <= csp_pkg::RST_BLUE_HIGH;
      settle_r         <= csp_pkg::RST_SETTLE;
    end else begin
      cal_r    <= cal_nxt;
      settle_r <= settle_nxt;
    end
  end

  csp_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .sensor_level (in_sensor_level),
    .start_req    (in_start_req),
    .settle       (settle_r),
    .ctl          (f_ctl),
    .count        (f_count)
  );

  assign q_din              = {f_ctl, f_count};
  assign {q_ctl, q_count}   = q_dout;

  csp_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (accept),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  csp_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_ctl           (q_ctl),
    .q_count         (q_count),
    .q_pop           (q_pop),
    .cal             (cal_r),
    .out_valid       (out_valid),
    .out_pop         (out_pop),
    .out_filter_s2   (out_filter_s2),
    .out_filter_s3   (out_filter_s3),
    .out_busy_res    (out_busy_res),
    .out_color_valid (out_color_valid),
    .out_red_level   (out_red_level),
    .out_green_level (out_green_level),
    .out_blue_level  (out_blue_level)
  );

endmodule
